// ===== hdl/rpk_pkg.sv =====
// Shared types and constants for the seven/eight bit repacker.
package rpk_pkg;

    localparam int ACC_W   = 14;
    localparam int CNT_W   = 4;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Register indexes.
    localparam logic REG_DIRECTION = 1'b0;

    // Direction codes.
    localparam logic DIR_UNPACK = 1'b0;
    localparam logic DIR_PACK   = 1'b1;

    typedef struct packed {
        logic [7:0] data_in;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] data_out;
        logic       out_last;
    } t_out_item;

    // Results caused by one input item: one or two of them.
    typedef struct packed {
        logic      two;
        t_out_item first;
        t_out_item second;
    } t_job;

    // Configuration write toward the front part.
    typedef struct packed {
        logic wr;
        logic dir;
    } t_cfg;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic nonempty;
    } t_q_status;

endpackage

// ===== hdl/rpk_front.sv =====
// Front part: accepts input items, runs the bit accumulator and forms result jobs.
module rpk_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rpk_pkg::t_cfg     i_cfg,
    input  logic              i_valid,
    input  rpk_pkg::t_in_item i_item,
    output logic              o_ready,
    input  rpk_pkg::t_q_status i_q_status,
    output logic              o_push,
    output rpk_pkg::t_job     o_job,
    output logic              o_dir
);

    logic                       r_dir;
    logic [rpk_pkg::ACC_W-1:0]  r_acc;
    logic [rpk_pkg::CNT_W-1:0]  r_cnt;
    logic [rpk_pkg::ACC_W-1:0]  n_acc;
    logic [rpk_pkg::CNT_W-1:0]  n_cnt;

    logic [7:0]                 w_in_bits;
    logic [7:0]                 w_mask;
    logic [rpk_pkg::CNT_W-1:0]  w_out_w;
    logic [rpk_pkg::ACC_W-1:0]  w_acc_sum;
    logic [rpk_pkg::CNT_W-1:0]  w_cnt_sum;
    logic [rpk_pkg::ACC_W-1:0]  w_acc1;
    logic [rpk_pkg::CNT_W-1:0]  w_cnt1;
    logic [rpk_pkg::ACC_W-1:0]  w_acc_f;
    logic [rpk_pkg::CNT_W-1:0]  w_cnt_f;
    logic                       w_full0;
    logic                       w_full1;
    logic                       w_flush;
    logic                       w_accept;

    assign o_ready  = !i_q_status.full;
    assign w_accept = i_valid && o_ready;
    assign o_dir    = r_dir;

    always_comb begin
        w_in_bits = (r_dir == rpk_pkg::DIR_PACK) ? i_item.data_in
                                                 : {1'b0, i_item.data_in[6:0]};
        w_mask    = (r_dir == rpk_pkg::DIR_PACK) ? 8'h7F : 8'hFF;
        w_out_w   = (r_dir == rpk_pkg::DIR_PACK) ? 4'd7 : 4'd8;
        // Pending bits never exceed seven here, so the new bits land inside 14 bits.
        w_acc_sum = r_acc | ({6'b0, w_in_bits} << r_cnt[2:0]);
        w_cnt_sum = r_cnt + ((r_dir == rpk_pkg::DIR_PACK) ? 4'd8 : 4'd7);

        w_full0 = (w_cnt_sum >= w_out_w);
        w_acc1  = (r_dir == rpk_pkg::DIR_PACK) ? (w_acc_sum >> 7) : (w_acc_sum >> 8);
        w_cnt1  = w_cnt_sum - w_out_w;
        w_full1 = w_full0 && (w_cnt1 >= w_out_w);

        if (w_full1) begin
            w_acc_f = w_acc1 >> 7;
            w_cnt_f = w_cnt1 - w_out_w;
        end else if (w_full0) begin
            w_acc_f = w_acc1;
            w_cnt_f = w_cnt1;
        end else begin
            w_acc_f = w_acc_sum;
            w_cnt_f = w_cnt_sum;
        end

        // Leftover bits at the end of a message go out as one short unit.
        w_flush = i_item.in_last && (w_cnt_f != '0) && !w_full1;

        o_job.two             = w_full1 || (w_full0 && w_flush);
        o_job.first.data_out  = w_acc_sum[7:0] & w_mask;
        o_job.first.out_last  = i_item.in_last && !o_job.two;
        o_job.second.data_out = w_acc1[7:0] & w_mask;
        o_job.second.out_last = i_item.in_last;

        o_push = w_accept && (w_full0 || w_flush);

        if (i_item.in_last) begin
            n_acc = '0;
            n_cnt = '0;
        end else begin
            n_acc = w_acc_f;
            n_cnt = w_cnt_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= rpk_pkg::DIR_UNPACK;
            r_acc <= '0;
            r_cnt <= '0;
        end else if (i_cfg.wr) begin
            r_dir <= i_cfg.dir;
            r_acc <= '0;
            r_cnt <= '0;
        end else if (w_accept) begin
            r_acc <= n_acc;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== hdl/rpk_queue.sv =====
// Short job queue between the front and back parts.
module rpk_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rpk_pkg::t_job      i_job,
    input  logic               i_pop,
    output rpk_pkg::t_job      o_job,
    output rpk_pkg::t_q_status o_status
);

    rpk_pkg::t_job               r_mem [rpk_pkg::QDEPTH];
    logic [rpk_pkg::QPTR_W-1:0]  r_wr;
    logic [rpk_pkg::QPTR_W-1:0]  r_rd;
    logic [rpk_pkg::QCNT_W-1:0]  r_cnt;
    logic                        w_push;
    logic                        w_pop;

    assign o_status.full     = (r_cnt == rpk_pkg::QCNT_W'(rpk_pkg::QDEPTH));
    assign o_status.nonempty = (r_cnt != '0);
    assign w_push            = i_push && !o_status.full;
    assign w_pop             = i_pop && o_status.nonempty;
    assign o_job             = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/rpk_back.sv =====
// Back part: takes jobs from the queue and sends their results one per cycle while i_ready is high.
module rpk_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rpk_pkg::t_q_status i_q_status,
    input  rpk_pkg::t_job      i_job,
    output logic               o_pop,
    output logic               o_valid,
    output rpk_pkg::t_out_item o_item,
    input  logic               i_ready
);

    logic          r_busy;
    logic          r_second;
    rpk_pkg::t_job r_job;
    logic          w_take;
    logic          w_done;

    assign o_valid = r_busy;
    assign o_item  = r_second ? r_job.second : r_job.first;
    assign w_take  = r_busy && i_ready;
    assign w_done  = w_take && (r_second || !r_job.two);
    assign o_pop   = (!r_busy || w_done) && i_q_status.nonempty;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_second <= 1'b0;
        end else if (o_pop) begin
            r_busy   <= 1'b1;
            r_second <= 1'b0;
        end else if (w_done) begin
            r_busy   <= 1'b0;
            r_second <= 1'b0;
        end else if (w_take) begin
            r_second <= 1'b1;
        end
    end

endmodule

// ===== hdl/seven_eight_bit_repacker.sv =====
// Top level of the seven/eight bit repacker: configuration port and part wiring.
// An accepted item's job is written into the queue and then loaded into the back part,
// which presents its result and keeps it valid until it is taken.
// Throughput: one item per cycle while the queue has room; an item with two results
// holds the output until both are taken; pack mode gives eight results per seven items.
// Reset: i_rst_n is synchronous and active low; it clears the accumulator, the queue
// and the output stage, and sets direction to unpack.
module seven_eight_bit_repacker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Input item channel.
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  rpk_pkg::t_in_item           i_in_item,
    // Result item channel.
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output rpk_pkg::t_out_item          o_out_item,
    // Configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rpk_pkg::PADDR_W-1:0] paddr,
    input  logic [rpk_pkg::PDATA_W-1:0] pwdata,
    output logic [rpk_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    // The register index is the word address; only the direction register exists.
    // Any write to it also clears the pending bits of the accumulator.
    rpk_pkg::t_cfg      w_cfg;
    rpk_pkg::t_q_status w_q_status;
    rpk_pkg::t_job      w_push_job;
    rpk_pkg::t_job      w_pop_job;
    logic               w_push;
    logic               w_pop;
    logic               w_dir;
    logic               w_sel_dir;

    assign pready    = 1'b1;
    assign w_sel_dir = (paddr[2] == rpk_pkg::REG_DIRECTION);
    assign w_cfg.wr  = psel && penable && pwrite && pready && w_sel_dir;
    assign w_cfg.dir = pwdata[0];
    assign prdata    = w_sel_dir ? {{(rpk_pkg::PDATA_W-1){1'b0}}, w_dir} : '0;

    // The front part accepts items whenever the queue has room, so an item is
    // taken even while the back part holds a result that has not been collected.
    rpk_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_valid    (i_in_valid),
        .i_item     (i_in_item),
        .o_ready    (o_in_ready),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_job      (w_push_job),
        .o_dir      (w_dir)
    );

    // Items that yield no result are never queued.
    rpk_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_push_job),
        .i_pop    (w_pop),
        .o_job    (w_pop_job),
        .o_status (w_q_status)
    );

    // The back part walks through the one or two results of each job in order.
    rpk_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (w_q_status),
        .i_job      (w_pop_job),
        .o_pop      (w_pop),
        .o_valid    (o_out_valid),
        .o_item     (o_out_item),
        .i_ready    (i_out_ready)
    );

endmodule

// ===== hdl/rpk_checker.sv =====
// Port-level checks for the repacker and the bind that attaches them.
module rpk_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input rpk_pkg::t_out_item          o_out_item,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [rpk_pkg::PADDR_W-1:0] paddr,
    input logic [rpk_pkg::PDATA_W-1:0] pwdata,
    input logic [rpk_pkg::PDATA_W-1:0] prdata
);

    // A result that is not taken stays on the output unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // Reset empties the output stage.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Reset leaves the queue empty, so input is accepted right away.
    a_reset_in: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready after reset");

    // A direction write is seen by the next read of that register.
    a_dir_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && (paddr[2] == rpk_pkg::REG_DIRECTION)
        |=> (paddr[2] != rpk_pkg::REG_DIRECTION) || (prdata[0] == $past(pwdata[0])))
        else $error("direction readback mismatch");

endmodule

bind seven_eight_bit_repacker rpk_checker u_rpk_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata)
);
